FILE: rtl/mlds_pkg.sv
// package for the multi-light diffuse shader: payload structs, codes,
// light table word, controller/datapath command and status types
// no dependencies
package mlds_pkg;

  localparam int unsigned CH_W  = 16;
  localparam int unsigned VEC_W = 48;

  // input item
  typedef struct packed {
    logic [1:0]       mode;
    logic [1:0]       light_kind;
    logic [VEC_W-1:0] vec_a;
    logic [VEC_W-1:0] vec_b;
    logic [VEC_W-1:0] vec_c;
    logic [VEC_W-1:0] vec_d;
    logic [CH_W-1:0]  scalar_a;
    logic [CH_W-1:0]  scalar_b;
    logic             emissive_on;
    logic [3:0]       target_light;
    logic             enable_flag;
  } mlds_in_t;

  // result item
  typedef struct packed {
    logic [CH_W-1:0] color_r;
    logic [CH_W-1:0] color_g;
    logic [CH_W-1:0] color_b;
    logic [3:0]      light_index;
    logic [1:0]      status;
  } mlds_out_t;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_ENABLE = 2'd1,
    MODE_SHADE  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mlds_mode_e;

  localparam logic [1:0] KIND_DIR   = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic CFG_AMB_RGB  = 1'b0;
  localparam logic CFG_AMB_GAIN = 1'b1;

  localparam logic [VEC_W-1:0] AMB_RGB_RST  = 48'h009A_0080_0066;
  localparam logic [CH_W-1:0]  AMB_GAIN_RST = 16'd154;

  // selector value that picks the attenuation divide
  localparam logic [1:0] SEL_ATTEN = 2'd3;

  // one light table entry
  typedef struct packed {
    logic [1:0]       kind;
    logic [VEC_W-1:0] pos;
    logic [VEC_W-1:0] dir;
    logic [VEC_W-1:0] rgb;
    logic [CH_W-1:0]  gain;
    logic [CH_W-1:0]  reach;
  } mlds_light_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_ADD,
    OP_ENABLE,
    OP_CLEAR,
    OP_RESULT,
    OP_T_AMB,
    OP_T_FACTOR,
    OP_ACC_ALBEDO,
    OP_ACC_EMIS,
    OP_PTR_CLR,
    OP_PTR_INC,
    OP_DIFF,
    OP_SQ,
    OP_SQRT_START,
    OP_DIV_START,
    OP_DIV_STORE,
    OP_DOT,
    OP_NDOTL,
    OP_T_LGAIN,
    OP_T_NDOTL,
    OP_T_ATTEN
  } mlds_op_e;

  typedef struct packed {
    mlds_op_e   op;
    logic [1:0] sel;
  } mlds_cmd_t;

  typedef struct packed {
    logic       busy;
    logic       ptr_end;
    logic       light_on;
    logic [1:0] kind;
    logic       skip;
  } mlds_stat_t;

  function automatic logic [CH_W-1:0] chan16(logic [VEC_W-1:0] v, logic [1:0] k);
    logic [CH_W-1:0] c;
    unique case (k)
      2'd1:    c = v[31:16];
      2'd2:    c = v[47:32];
      default: c = v[15:0];
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/multi_light_diffuse_shader_core.sv
// top level of the multi-light diffuse shader
// depends on mlds_pkg, mlds_ctrl, mlds_datapath (and mlds_ram through it)
//
// the core holds a table of up to MAX_LIGHTS lights and answers every input
// transfer with exactly one result transfer. mode 0 appends a light and
// returns its index or a table-full status, mode 1 sets one light's enable
// or flags an index out of range, mode 3 empties the table, and mode 2 shades
// a surface point: ambient times albedo, plus the emissive term when that is
// on, plus lambert diffuse from each enabled directional and point light with
// linear falloff, each channel saturated to unsigned q8.8. items are handled
// one at a time. disabled, spot and unknown lights add nothing; each point
// light runs an iterative square root (one result bit a cycle) and, unless
// it sits at zero distance or beyond its range, four restoring divides (one
// quotient bit a cycle) on the shared arithmetic of the datapath.
// a finished result sits in the output register until taken; the
// next input is accepted only once the current result has been loaded there.
// config writes are always taken and apply at once.
module multi_light_diffuse_shader_core
  import mlds_pkg::*;
#(
  parameter int unsigned MAX_LIGHTS    = 16,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // item input
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mlds_in_t         in_data_i,
  // result output
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mlds_out_t        out_data_o,
  // register writes: index 0 ambient colour, index 1 ambient gain
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic             cfg_index_i,
  input  logic [VEC_W-1:0] cfg_data_i
);

  mlds_cmd_t  cmd;
  mlds_stat_t stat;

  // registers never stall a transfer
  assign cfg_ready_o = 1'b1;

  // sequencer: one micro-op per cycle, waits on the iterative units
  mlds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (in_data_i.mode),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: light table, arithmetic, accumulators, output register
  mlds_datapath #(
    .MAX_LIGHTS    (MAX_LIGHTS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_i        (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stat_o      (stat),
    .res_o       (out_data_o)
  );

endmodule

FILE: rtl/mlds_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mlds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/mlds_ctrl.sv
// sequencer for the shader: walks the micro-op sequence of each item
// depends on mlds_pkg
module mlds_ctrl
  import mlds_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] mode_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  mlds_stat_t stat_i,
  output mlds_cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_EXEC, S_AMB0, S_AMB1, S_AMB2, S_EMIS, S_LCLR, S_LWAIT, S_LCHK,
    S_SQ, S_SQRT_GO, S_SQRT_WAIT, S_DIV_GO, S_DIV_WAIT, S_DOT, S_NDOTL,
    S_L0, S_L1, S_L2, S_L3, S_NEXT, S_FINISH
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  mlds_mode_e mode_q, mode_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mode_d      = mode_q;
    out_valid_d = out_valid_q;
    cmd_o.op    = OP_NOP;
    cmd_o.sel   = cnt_q;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_CAPTURE;
          mode_d   = mlds_mode_e'(mode_i);
          cnt_d    = '0;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (mode_q)
          MODE_ADD: begin
            cmd_o.op = OP_ADD;
            state_d  = S_FINISH;
          end
          MODE_ENABLE: begin
            cmd_o.op = OP_ENABLE;
            state_d  = S_FINISH;
          end
          MODE_CLEAR: begin
            cmd_o.op = OP_CLEAR;
            state_d  = S_FINISH;
          end
          default: state_d = S_AMB0;
        endcase
      end
      S_AMB0: begin
        cmd_o.op = OP_T_AMB;
        state_d  = S_AMB1;
      end
      S_AMB1: begin
        cmd_o.op = OP_T_FACTOR;
        state_d  = S_AMB2;
      end
      S_AMB2: begin
        cmd_o.op = OP_ACC_ALBEDO;
        state_d  = S_EMIS;
      end
      S_EMIS: begin
        cmd_o.op = OP_ACC_EMIS;
        if (cnt_q == 2'd2) begin
          cnt_d   = '0;
          state_d = S_LCLR;
        end else begin
          cnt_d   = cnt_q + 2'd1;
          state_d = S_AMB0;
        end
      end
      S_LCLR: begin
        cmd_o.op = OP_PTR_CLR;
        state_d  = S_LWAIT;
      end
      S_LWAIT: state_d = S_LCHK;
      S_LCHK: begin
        if (stat_i.ptr_end) begin
          state_d = S_FINISH;
        end else if (!stat_i.light_on ||
                     (stat_i.kind != KIND_DIR && stat_i.kind != KIND_POINT)) begin
          state_d = S_NEXT;
        end else begin
          cmd_o.op = OP_DIFF;
          cnt_d    = '0;
          state_d  = (stat_i.kind == KIND_DIR) ? S_DOT : S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.op = OP_SQ;
        if (cnt_q == 2'd2) begin
          cnt_d   = '0;
          state_d = S_SQRT_GO;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      S_SQRT_GO: begin
        cmd_o.op = OP_SQRT_START;
        state_d  = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (!stat_i.busy) begin
          cnt_d   = '0;
          state_d = stat_i.skip ? S_NEXT : S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd_o.op = OP_DIV_START;
        state_d  = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!stat_i.busy) begin
          cmd_o.op = OP_DIV_STORE;
          if (cnt_q == SEL_ATTEN) begin
            cnt_d   = '0;
            state_d = S_DOT;
          end else begin
            cnt_d   = cnt_q + 2'd1;
            state_d = S_DIV_GO;
          end
        end
      end
      S_DOT: begin
        cmd_o.op = OP_DOT;
        if (cnt_q == 2'd2) begin
          cnt_d   = '0;
          state_d = S_NDOTL;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      S_NDOTL: begin
        cmd_o.op = OP_NDOTL;
        cnt_d    = '0;
        state_d  = S_L0;
      end
      S_L0: begin
        cmd_o.op = OP_T_LGAIN;
        state_d  = S_L1;
      end
      S_L1: begin
        cmd_o.op = OP_T_NDOTL;
        state_d  = S_L2;
      end
      S_L2: begin
        cmd_o.op = OP_T_ATTEN;
        state_d  = S_L3;
      end
      S_L3: begin
        cmd_o.op = OP_ACC_ALBEDO;
        if (cnt_q == 2'd2) begin
          cnt_d   = '0;
          state_d = S_NEXT;
        end else begin
          cnt_d   = cnt_q + 2'd1;
          state_d = S_L0;
        end
      end
      S_NEXT: begin
        cmd_o.op = OP_PTR_INC;
        state_d  = S_LWAIT;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_RESULT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      mode_q      <= MODE_ADD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/mlds_datapath.sv
// shader datapath: light table, config registers, q-format multiplier,
// iterative square root and divider, accumulators and result register
// depends on mlds_pkg and mlds_ram
module mlds_datapath
  import mlds_pkg::*;
#(
  parameter int unsigned MAX_LIGHTS    = 16,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mlds_cmd_t        cmd_i,
  input  mlds_in_t         in_i,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [VEC_W-1:0] cfg_data_i,
  output mlds_stat_t       stat_o,
  output mlds_out_t        res_o
);

  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned PW   = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int unsigned UW   = $clog2(MAX_LIGHTS + 1);
  localparam int unsigned NW   = 16 + F;
  localparam int unsigned DIRW = 17 + F;
  localparam int unsigned SW   = DIRW + 19;
  localparam int unsigned AW   = F + 1;
  localparam int unsigned ACCW = 33 + $clog2(MAX_LIGHTS + 2);
  localparam int unsigned RW   = 35;
  localparam int unsigned CW   = $clog2(NW + 1);
  localparam int unsigned LW   = $bits(mlds_light_t);
  localparam logic [AW-1:0] ONE = {1'b1, {F{1'b0}}};

  // control state
  logic [VEC_W-1:0] amb_rgb_q;
  logic [CH_W-1:0]  amb_gain_q;
  logic [UW-1:0]    used_q;
  logic [UW-1:0]    ptr_q;
  logic             sq_busy_q, dv_busy_q;
  logic [CW-1:0]    dv_cnt_q;

  // payload
  mlds_in_t               in_q;
  mlds_out_t              res_q;
  logic [1:0]             stat_q;
  logic [3:0]             idx_q;
  logic [ACCW-1:0]        acc_q [3];
  logic [31:0]            t_q;
  logic signed [16:0]     d_q [3];
  logic [33:0]            d2_q;
  logic [16:0]            dist_q;
  logic signed [DIRW-1:0] dir_q [3];
  logic [AW-1:0]          atten_q;
  logic signed [SW-1:0]   s_q;
  logic [31:0]            ndotl_q;
  logic                   on_q [MAX_LIGHTS];
  logic [RW-1:0]          sq_v_q, sq_r_q, sq_bit_q;
  logic [15:0]            dv_rem_q, dv_den_q;
  logic [NW-1:0]          dv_quo_q;
  logic                   dv_neg_q;

  mlds_light_t lw;
  logic [LW-1:0] lw_raw;
  logic full, add_ok, en_ok;

  assign full   = used_q >= UW'(MAX_LIGHTS);
  assign add_ok = (cmd_i.op == OP_ADD) && !full;
  assign en_ok  = 8'(in_q.target_light) < 8'(used_q);

  mlds_ram #(.WIDTH(LW), .DEPTH(MAX_LIGHTS)) u_table (
    .clk_i   (clk_i),
    .we_i    (add_ok),
    .waddr_i (used_q[PW-1:0]),
    .wdata_i ({in_q.light_kind, in_q.vec_a, in_q.vec_b, in_q.vec_c,
               in_q.scalar_a, in_q.scalar_b}),
    .raddr_i (ptr_q[PW-1:0]),
    .rdata_o (lw_raw)
  );
  assign lw = mlds_light_t'(lw_raw);

  // per-channel selections
  logic signed [16:0]     d_sel;
  logic signed [DIRW-1:0] dir_sel;
  logic [15:0]            d_mag;
  always_comb begin
    d_sel   = d_q[0];
    dir_sel = dir_q[0];
    for (int k = 1; k < 3; k++) begin
      if (cmd_i.sel == 2'(k)) begin
        d_sel   = d_q[k];
        dir_sel = dir_q[k];
      end
    end
    d_mag = d_sel[16] ? 16'(-d_sel) : d_sel[15:0];
  end

  // q-format multiply with truncation and 32-bit saturation
  logic [31:0] qa, qb, qres;
  logic [63:0] qprod, qshift;
  always_comb begin
    unique case (cmd_i.op)
      OP_T_AMB: begin
        qa = 32'(chan16(amb_rgb_q, cmd_i.sel));
        qb = 32'(amb_gain_q);
      end
      OP_T_FACTOR: begin
        qa = t_q;
        qb = 32'(in_q.scalar_a);
      end
      OP_ACC_ALBEDO: begin
        qa = t_q;
        qb = 32'(chan16(in_q.vec_c, cmd_i.sel));
      end
      OP_ACC_EMIS: begin
        qa = 32'(chan16(in_q.vec_d, cmd_i.sel));
        qb = 32'(in_q.scalar_b);
      end
      OP_T_LGAIN: begin
        qa = 32'(chan16(lw.rgb, cmd_i.sel));
        qb = 32'(lw.gain);
      end
      OP_T_NDOTL: begin
        qa = t_q;
        qb = ndotl_q;
      end
      OP_T_ATTEN: begin
        qa = t_q;
        qb = 32'(atten_q);
      end
      default: begin
        qa = t_q;
        qb = '0;
      end
    endcase
    qprod  = qa * qb;
    qshift = qprod >> F;
    qres   = (|qshift[63:32]) ? 32'hFFFF_FFFF : qshift[31:0];
  end

  // squared distance term, dot product term, clamped lambert factor
  logic signed [33:0]   sq_prod;
  logic signed [SW-1:0] dot_prod, s_neg;
  logic [SW-1:0]        s_shr;
  logic [31:0]          ndotl_d;
  always_comb begin
    sq_prod  = d_sel * d_sel;
    dot_prod = SW'($signed(chan16(in_q.vec_b, cmd_i.sel))) * SW'(dir_sel);
    s_neg    = -s_q;
    s_shr    = $unsigned(s_neg) >> F;
    if (s_neg > 0) begin
      ndotl_d = (|s_shr[SW-1:32]) ? 32'hFFFF_FFFF : s_shr[31:0];
    end else begin
      ndotl_d = '0;
    end
  end

  // one digit pair of the square root per cycle
  logic [RW-1:0] sq_sum, sq_v_n, sq_r_n;
  always_comb begin
    sq_sum = sq_r_q + sq_bit_q;
    if (sq_v_q >= sq_sum) begin
      sq_v_n = sq_v_q - sq_sum;
      sq_r_n = (sq_r_q >> 1) + sq_bit_q;
    end else begin
      sq_v_n = sq_v_q;
      sq_r_n = sq_r_q >> 1;
    end
  end

  // one quotient bit per cycle, restoring
  logic [16:0] dv_trial;
  logic        dv_ge;
  always_comb begin
    dv_trial = {dv_rem_q, dv_quo_q[NW-1]};
    dv_ge    = dv_trial >= {1'b0, dv_den_q};
  end

  function automatic logic [CH_W-1:0] sat16(logic [ACCW-1:0] a);
    return (a > ACCW'(16'hFFFF)) ? 16'hFFFF : a[15:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amb_rgb_q  <= AMB_RGB_RST;
      amb_gain_q <= AMB_GAIN_RST;
      used_q     <= '0;
      ptr_q      <= '0;
      sq_busy_q  <= 1'b0;
      dv_busy_q  <= 1'b0;
      dv_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_AMB_RGB:  amb_rgb_q  <= cfg_data_i;
          CFG_AMB_GAIN: amb_gain_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (add_ok) begin
        used_q <= used_q + UW'(1);
      end else if (cmd_i.op == OP_CLEAR) begin
        used_q <= '0;
      end
      if (cmd_i.op == OP_PTR_CLR) begin
        ptr_q <= '0;
      end else if (cmd_i.op == OP_PTR_INC) begin
        ptr_q <= ptr_q + UW'(1);
      end
      if (cmd_i.op == OP_SQRT_START) begin
        sq_busy_q <= 1'b1;
      end else if (sq_busy_q && sq_bit_q[0]) begin
        sq_busy_q <= 1'b0;
      end
      if (cmd_i.op == OP_DIV_START) begin
        dv_busy_q <= 1'b1;
        dv_cnt_q  <= CW'(NW);
      end else if (dv_busy_q) begin
        dv_cnt_q <= dv_cnt_q - CW'(1);
        if (dv_cnt_q == CW'(1)) begin
          dv_busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_LIGHTS; j++) begin
      if (add_ok && 8'(used_q) == 8'(j)) begin
        on_q[j] <= 1'b1;
      end else if (cmd_i.op == OP_ENABLE && en_ok && 8'(in_q.target_light) == 8'(j)) begin
        on_q[j] <= in_q.enable_flag;
      end
    end

    if (cmd_i.op == OP_SQRT_START) begin
      sq_v_q   <= RW'(d2_q);
      sq_r_q   <= '0;
      sq_bit_q <= RW'(1) << 32;
    end else if (sq_busy_q) begin
      sq_v_q   <= sq_v_n;
      sq_r_q   <= sq_r_n;
      sq_bit_q <= sq_bit_q >> 2;
      if (sq_bit_q[0]) begin
        dist_q <= sq_r_n[16:0];
      end
    end

    if (cmd_i.op == OP_DIV_START) begin
      dv_rem_q <= '0;
      if (cmd_i.sel == SEL_ATTEN) begin
        dv_quo_q <= {dist_q[15:0], {F{1'b0}}};
        dv_den_q <= lw.reach;
        dv_neg_q <= 1'b0;
      end else begin
        dv_quo_q <= {d_mag, {F{1'b0}}};
        dv_den_q <= dist_q[15:0];
        dv_neg_q <= d_sel[16];
      end
    end else if (dv_busy_q) begin
      dv_rem_q <= dv_ge ? 16'(dv_trial - {1'b0, dv_den_q}) : dv_trial[15:0];
      dv_quo_q <= {dv_quo_q[NW-2:0], dv_ge};
    end

    unique case (cmd_i.op)
      OP_CAPTURE: begin
        in_q   <= in_i;
        stat_q <= ST_OK;
        idx_q  <= '0;
        for (int k = 0; k < 3; k++) acc_q[k] <= '0;
      end
      OP_ADD: begin
        if (full) stat_q <= ST_FULL;
        else      idx_q  <= 4'(used_q);
      end
      OP_ENABLE: begin
        if (!en_ok) stat_q <= ST_RANGE;
      end
      OP_RESULT: begin
        res_q.color_r     <= sat16(acc_q[0]);
        res_q.color_g     <= sat16(acc_q[1]);
        res_q.color_b     <= sat16(acc_q[2]);
        res_q.light_index <= idx_q;
        res_q.status      <= stat_q;
      end
      OP_T_AMB, OP_T_FACTOR, OP_T_LGAIN, OP_T_NDOTL, OP_T_ATTEN: begin
        t_q <= qres;
      end
      OP_ACC_ALBEDO: begin
        for (int k = 0; k < 3; k++) begin
          if (cmd_i.sel == 2'(k)) acc_q[k] <= acc_q[k] + ACCW'(qres);
        end
      end
      OP_ACC_EMIS: begin
        for (int k = 0; k < 3; k++) begin
          if (cmd_i.sel == 2'(k) && in_q.emissive_on) acc_q[k] <= acc_q[k] + ACCW'(qres);
        end
      end
      OP_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          d_q[k]   <= 17'($signed(chan16(lw.pos, 2'(k)))) -
                      17'($signed(chan16(in_q.vec_a, 2'(k))));
          dir_q[k] <= DIRW'($signed(chan16(lw.dir, 2'(k))));
        end
        atten_q <= ONE;
      end
      OP_SQ: begin
        d2_q <= ((cmd_i.sel == 2'd0) ? 34'd0 : d2_q) + $unsigned(sq_prod);
      end
      OP_DIV_STORE: begin
        if (cmd_i.sel == SEL_ATTEN) begin
          atten_q <= ONE - AW'(dv_quo_q);
        end else begin
          for (int k = 0; k < 3; k++) begin
            if (cmd_i.sel == 2'(k)) begin
              dir_q[k] <= dv_neg_q ? -$signed({1'b0, dv_quo_q}) : $signed({1'b0, dv_quo_q});
            end
          end
        end
      end
      OP_DOT: begin
        s_q <= ((cmd_i.sel == 2'd0) ? SW'(0) : s_q) + dot_prod;
      end
      OP_NDOTL: ndotl_q <= ndotl_d;
      default: ;
    endcase
  end

  assign stat_o.busy     = sq_busy_q | dv_busy_q;
  assign stat_o.ptr_end  = ptr_q >= used_q;
  assign stat_o.light_on = on_q[ptr_q[PW-1:0]];
  assign stat_o.kind     = lw.kind;
  assign stat_o.skip     = (dist_q == '0) || (dist_q > 17'(lw.reach));
  assign res_o           = res_q;

endmodule

FILE: sim/mlds_checker.sv
// prediction and scoreboard for the multi-light diffuse shader core
// depends on mlds_pkg; watches the item, result and register channels
`timescale 1ns / 1ps

module mlds_checker
  import mlds_pkg::*;
#(
  parameter int unsigned MAX_LIGHTS    = 16,
  parameter int unsigned FRACTION_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  mlds_in_t         in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  mlds_out_t        out_data_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic             cfg_index_i,
  input  logic [VEC_W-1:0] cfg_data_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               shades_o
);

  localparam longint unsigned Q_ONE = 64'd1 << FRACTION_BITS;
  localparam longint unsigned SAT32 = 64'hFFFF_FFFF;

  logic [VEC_W-1:0] amb_rgb;
  logic [CH_W-1:0]  amb_gain;
  int unsigned      lights_used;
  logic [1:0]       lt_kind  [MAX_LIGHTS];
  logic [VEC_W-1:0] lt_pos   [MAX_LIGHTS];
  logic [VEC_W-1:0] lt_dir   [MAX_LIGHTS];
  logic [VEC_W-1:0] lt_rgb   [MAX_LIGHTS];
  logic [CH_W-1:0]  lt_gain  [MAX_LIGHTS];
  logic [CH_W-1:0]  lt_reach [MAX_LIGHTS];
  logic             lt_on    [MAX_LIGHTS];

  mlds_out_t expected_colors_q[$];

  function automatic longint unsigned lane(logic [VEC_W-1:0] v, int k);
    return longint'((v >> (16 * k)) & 48'hFFFF);
  endfunction

  function automatic longint signed slane(logic [VEC_W-1:0] v, int k);
    longint signed c = longint'(lane(v, k));
    if (c >= 32768) c -= 65536;
    return c;
  endfunction

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    longint unsigned p;
    if (a > SAT32) a = SAT32;
    if (b > SAT32) b = SAT32;
    p = (a * b) >> FRACTION_BITS;
    return (p > SAT32) ? SAT32 : p;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [CH_W-1:0] sat16(longint unsigned v);
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  // lit colour of one surface point from the current light set
  function automatic mlds_out_t shade_point(mlds_in_t it);
    longint unsigned acc[3];
    longint unsigned t, ndotl, atten, d2, dist_v;
    longint signed   d[3], dv[3], s;
    mlds_out_t       r;
    for (int k = 0; k < 3; k++) begin
      t = qmul(lane(amb_rgb, k), amb_gain);
      t = qmul(t, it.scalar_a);
      acc[k] = qmul(t, lane(it.vec_c, k));
      if (it.emissive_on) acc[k] += qmul(lane(it.vec_d, k), it.scalar_b);
    end
    for (int i = 0; i < lights_used && i < MAX_LIGHTS; i++) begin
      if (!lt_on[i]) continue;
      atten = Q_ONE;
      if (lt_kind[i] == KIND_DIR) begin
        for (int k = 0; k < 3; k++) dv[k] = slane(lt_dir[i], k);
      end else if (lt_kind[i] == KIND_POINT) begin
        d2 = 0;
        for (int k = 0; k < 3; k++) begin
          d[k] = slane(lt_pos[i], k) - slane(it.vec_a, k);
          d2 += longint'(d[k] * d[k]);
        end
        dist_v = int_sqrt(d2);
        // zero distance and beyond-range lights are dark
        if (dist_v == 0 || dist_v > lt_reach[i]) continue;
        for (int k = 0; k < 3; k++) dv[k] = (d[k] * longint'(Q_ONE)) / longint'(dist_v);
        atten = Q_ONE - (dist_v * Q_ONE) / lt_reach[i];
      end else begin
        continue;  // spot and unknown kinds add nothing
      end
      s = 0;
      for (int k = 0; k < 3; k++) s += slane(it.vec_b, k) * dv[k];
      s = -s;
      ndotl = (s > 0) ? (longint'(s) >> FRACTION_BITS) : 0;
      for (int k = 0; k < 3; k++) begin
        t = qmul(lane(lt_rgb[i], k), lt_gain[i]);
        t = qmul(t, ndotl);
        t = qmul(t, atten);
        acc[k] += qmul(t, lane(it.vec_c, k));
      end
    end
    r = '0;
    r.color_r = sat16(acc[0]);
    r.color_g = sat16(acc[1]);
    r.color_b = sat16(acc[2]);
    r.status  = ST_OK;
    return r;
  endfunction

  // apply one item to the light set and return its answer
  function automatic mlds_out_t apply_item(mlds_in_t it);
    mlds_out_t r = '0;
    case (mlds_mode_e'(it.mode))
      MODE_ADD: begin
        if (lights_used >= MAX_LIGHTS) begin
          r.status = ST_FULL;
        end else begin
          lt_kind[lights_used]  = it.light_kind;
          lt_pos[lights_used]   = it.vec_a;
          lt_dir[lights_used]   = it.vec_b;
          lt_rgb[lights_used]   = it.vec_c;
          lt_gain[lights_used]  = it.scalar_a;
          lt_reach[lights_used] = it.scalar_b;
          lt_on[lights_used]    = 1'b1;
          r.light_index = lights_used[3:0];
          lights_used++;
        end
      end
      MODE_ENABLE: begin
        if (it.target_light >= lights_used) r.status = ST_RANGE;
        else lt_on[it.target_light] = it.enable_flag;
      end
      MODE_SHADE: r = shade_point(it);
      default:    lights_used = 0;
    endcase
    return r;
  endfunction

  function automatic void report(string what, int unsigned exp_v, int unsigned act_v);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("mismatch on %s: expected %0h, got %0h", what, exp_v, act_v);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mlds_out_t e;
    if (!rst_ni) begin
      amb_rgb      = AMB_RGB_RST;
      amb_gain     = AMB_GAIN_RST;
      lights_used  = 0;
      expected_colors_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      shades_o     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_AMB_RGB) amb_rgb = cfg_data_i;
        else amb_gain = cfg_data_i[CH_W-1:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_colors_q.size() == 0) begin
          report("unexpected result", 0, 32'(out_data_i));
        end else begin
          e = expected_colors_q.pop_front();
          if (e.color_r !== out_data_i.color_r) report("red", e.color_r, out_data_i.color_r);
          if (e.color_g !== out_data_i.color_g)
            report("green", e.color_g, out_data_i.color_g);
          if (e.color_b !== out_data_i.color_b) report("blue", e.color_b, out_data_i.color_b);
          if (e.light_index !== out_data_i.light_index)
            report("light index", e.light_index, out_data_i.light_index);
          if (e.status !== out_data_i.status) report("status", e.status, out_data_i.status);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.mode == MODE_SHADE) shades_o++;
        expected_colors_q.push_back(apply_item(in_data_i));
      end
      pending_o = expected_colors_q.size();
    end
  end

endmodule

FILE: sim/tb.sv
// top of the shader core regression: clock, reset, stimulus and verdict
// depends on mlds_pkg, multi_light_diffuse_shader_core and mlds_checker
`timescale 1ns / 1ps

module tb
  import mlds_pkg::*;
();

  localparam logic [1:0] KIND_SPOT  = 2'd2;
  localparam logic [1:0] KIND_ODD   = 2'd3;
  localparam int         LIMIT      = 10_000_000;  // cycles, far above the slowest run
  localparam int         QUIET_LO   = 20_000;      // window with no idling on either side
  localparam int         QUIET_HI   = 60_000;
  localparam int         HOLD_AT    = 3_000;       // receiver back-pressure burst
  localparam int         HOLD_LEN   = 6_000;
  localparam int         RAND_ITEMS = 600;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  mlds_in_t         in_data;
  logic             out_valid;
  logic             out_ready;
  mlds_out_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic             cfg_index;
  logic [VEC_W-1:0] cfg_data;

  int cycle;
  int fail_count;
  int pending;
  int shades;
  int items_sent;
  int settings_used;
  int hold_left;
  bit held;

  // clock: 12 ns period
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  multi_light_diffuse_shader_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  mlds_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .shades_o     (shades)
  );

  // watchdog on a free-running cycle count
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("timeout with %0d results outstanding", pending);
      $display("multi_light_diffuse_shader_core regression: fail");
      $finish;
    end
  end

  // random idling, about 36 in 100, none inside the quiet window
  function automatic bit idle_now();
    if (cycle >= QUIET_LO && cycle < QUIET_HI) return 1'b0;
    return $urandom_range(99) < 36;
  endfunction

  // result side: random stalls plus one long hold-off while the sender keeps offering
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      held      <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held && cycle >= HOLD_AT) begin
      held      <= 1'b1;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_now();
    end
  end

  // pack three 16-bit lanes, x or red in the low bits
  function automatic logic [VEC_W-1:0] vec3(int x, int y, int z);
    logic [15:0] a = x[15:0];
    logic [15:0] b = y[15:0];
    logic [15:0] c = z[15:0];
    return {c, b, a};
  endfunction

  function automatic logic [VEC_W-1:0] any_vec();
    logic [63:0] w = {$urandom(), $urandom()};
    return w[VEC_W-1:0];
  endfunction

  // signed components within +-span
  function automatic logic [VEC_W-1:0] near_vec(int span);
    return vec3(int'($urandom_range(2 * span)) - span, int'($urandom_range(2 * span)) - span,
                int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic logic [VEC_W-1:0] tint(int top);
    return vec3($urandom_range(top), $urandom_range(top), $urandom_range(top));
  endfunction

  // one random item; most are well formed, some carry raw noise in every vector and scalar field
  function automatic mlds_in_t random_item();
    mlds_in_t    it;
    int unsigned pick = $urandom_range(99);
    bit          noisy = $urandom_range(99) < 15;
    it.light_kind   = ($urandom_range(9) < 8) ? 2'($urandom_range(1)) : 2'($urandom_range(3));
    it.vec_a        = noisy ? any_vec() : near_vec(768);
    it.vec_b        = noisy ? any_vec() : near_vec(384);
    it.vec_c        = noisy ? any_vec() : tint(512);
    it.vec_d        = noisy ? any_vec() : tint(256);
    it.scalar_a     = noisy ? 16'($urandom) : 16'($urandom_range(16'h0200));
    it.scalar_b     = noisy ? 16'($urandom) : 16'($urandom_range(16'h0C00));
    it.emissive_on  = 1'($urandom_range(1));
    it.target_light = 4'($urandom_range(15));
    it.enable_flag  = 1'($urandom_range(1));
    if (pick < 14) it.mode = MODE_ADD;
    else if (pick < 24) it.mode = MODE_ENABLE;
    else if (pick < 94) it.mode = MODE_SHADE;
    else it.mode = MODE_CLEAR;
    return it;
  endfunction

  function automatic mlds_in_t make_item(mlds_mode_e m, logic [1:0] kind, logic [VEC_W-1:0] a,
                                         logic [VEC_W-1:0] b, logic [VEC_W-1:0] c,
                                         logic [CH_W-1:0] sa, logic [CH_W-1:0] sb);
    mlds_in_t it = '0;
    it.mode       = m;
    it.light_kind = kind;
    it.vec_a      = a;
    it.vec_b      = b;
    it.vec_c      = c;
    it.scalar_a   = sa;
    it.scalar_b   = sb;
    return it;
  endfunction

  // offer one item and hold it until the transfer; valid is only lowered while idling
  task automatic send_item(input mlds_in_t it);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // drain everything outstanding with the input lowered
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // register write, only issued with the core idle
  task automatic write_reg(input logic idx, input logic [VEC_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_ambient(input logic [VEC_W-1:0] rgb, input logic [CH_W-1:0] gain);
    write_reg(CFG_AMB_RGB, rgb);
    write_reg(CFG_AMB_GAIN, gain);
    settings_used++;
  endtask

  initial begin
    mlds_in_t it;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_AMB_RGB;
    cfg_data      = '0;
    items_sent    = 0;
    settings_used = 1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, saturating emissive term
    it = make_item(MODE_SHADE, KIND_DIR, '0, '0, {VEC_W{1'b1}}, 16'hFFFF, 16'hFFFF);
    it.vec_d       = {VEC_W{1'b1}};
    it.emissive_on = 1'b1;
    send_item(it);
    // enable on an empty table is out of range
    it = make_item(MODE_ENABLE, KIND_DIR, '0, '0, '0, '0, '0);
    it.enable_flag = 1'b1;
    send_item(it);
    // one of each kind: directional, point, spot, unknown, point with zero range
    send_item(make_item(MODE_ADD, KIND_DIR, '0, vec3(0, 0, 256), vec3(256, 128, 64),
                        16'h0100, '0));
    send_item(make_item(MODE_ADD, KIND_POINT, vec3(0, 0, 512), '0, vec3(200, 300, 400),
                        16'h0180, 16'h0400));
    send_item(make_item(MODE_ADD, KIND_SPOT, vec3(0, 0, 256), vec3(0, 0, 256),
                        vec3(256, 256, 256), 16'h0100, 16'h0400));
    send_item(make_item(MODE_ADD, KIND_ODD, vec3(0, 0, 256), vec3(0, 0, 256),
                        vec3(256, 256, 256), 16'h0100, 16'h0400));
    send_item(make_item(MODE_ADD, KIND_POINT, vec3(0, 0, 256), '0, vec3(256, 256, 256),
                        16'h0100, 16'h0000));
    // lit surface facing the lights
    send_item(make_item(MODE_SHADE, KIND_DIR, '0, vec3(0, 0, -256), vec3(256, 256, 256),
                        16'h0100, '0));
    // surface sitting on the point light: zero distance
    send_item(make_item(MODE_SHADE, KIND_DIR, vec3(0, 0, 512), vec3(0, 0, -256),
                        vec3(256, 256, 256), 16'h0100, '0));
    // extreme normal and colours
    send_item(make_item(MODE_SHADE, KIND_DIR, vec3(-32768, -32768, -32768),
                        vec3(-32768, -32768, -32768), {VEC_W{1'b1}}, 16'hFFFF, 16'hFFFF));
    // disable one light, out-of-range id, shade again
    it = make_item(MODE_ENABLE, KIND_DIR, '0, '0, '0, '0, '0);
    it.target_light = 4'd1;
    send_item(it);
    it.target_light = 4'd15;
    it.enable_flag  = 1'b1;
    send_item(it);
    send_item(make_item(MODE_SHADE, KIND_DIR, '0, vec3(0, 0, -256), vec3(256, 256, 256),
                        16'h0100, '0));
    // fill the table, then one add too many
    for (int i = 0; i < 11; i++)
      send_item(make_item(MODE_ADD, KIND_DIR, '0, near_vec(256), tint(256), 16'h0080, '0));
    send_item(make_item(MODE_ADD, KIND_POINT, '0, '0, tint(256), 16'h0080, 16'h0100));
    send_item(make_item(MODE_SHADE, KIND_DIR, '0, vec3(0, 0, -256), vec3(256, 256, 256),
                        16'h0100, '0));
    send_item(make_item(MODE_CLEAR, KIND_DIR, '0, '0, '0, '0, '0));

    // random phases, each under its own ambient setting, extremes first
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       set_ambient({VEC_W{1'b1}}, 16'hFFFF);
        1:       set_ambient('0, '0);
        2:       set_ambient(any_vec(), 16'($urandom));
        default: set_ambient(tint(512), 16'($urandom_range(16'h0200)));
      endcase
      for (int n = 0; n < RAND_ITEMS / 4; n++) send_item(random_item());
    end

    drain();
    $display("%0d items sent, %0d of them shading, across %0d ambient settings",
             items_sent, shades, settings_used);
    $display("lights of every kind, full and empty tables, stalls and a long output hold");
    if (fail_count == 0) begin
      $display("multi_light_diffuse_shader_core regression: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("multi_light_diffuse_shader_core regression: fail");
    end
    $finish;
  end

endmodule
